// File: rtl/core/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants of the driveline spring-damper clutch
// Beat formats, configuration register indexes, sequencer states and the
// request and status groups between the sequencer and the divider.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 31;

  localparam logic [CfgAddrW-1:0] CFG_STIFFNESS   = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_DAMPING     = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_FLEX_LIMIT  = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_FLEX_ENABLE = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_TIME_STEP   = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_FIRST_GND   = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_SECOND_GND  = 3'd6;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] first_velocity;
    logic signed [31:0] second_velocity;
    logic [30:0]        clutch_capacity;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] coupling_torque;
    logic               apply_first;
    logic               apply_second;
    logic               slipping;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MDT,
    S_DELTA,
    S_ANGLE,
    S_MKS,
    S_TSUM,
    S_TSAT,
    S_NUM,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        start;
    logic [62:0] num_mag;
    logic [30:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/core/driveline_spring_damper_clutch.sv
// ----------------------------------------------------------------------------
// driveline_spring_damper_clutch: spring-damper shaft coupling with clutch
// A disengaged clutch goes from the input beat straight to S_FIN; an engaged
// one steps through S_MDT to S_NUM, and slip with nonzero stiffness adds
// S_DIV for the divider. A new beat is taken only in S_IDLE, once the last is done.
// Reset (synchronous, rst_n low): wind-up angle and configuration registers zero,
// flex limit enabled; no result pending.
// ----------------------------------------------------------------------------
module driveline_spring_damper_clutch (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dsc_pkg::in_beat_t               in_beat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dsc_pkg::out_beat_t              out_beat,
  input  logic                            cfg_we,
  input  logic [dsc_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [dsc_pkg::CfgDataW-1:0]    cfg_wdata
);

  // Configuration registers.
  logic [30:0] ks_r, kd_r, lim_r;
  logic        lim_en_r, gnd1_r, gnd2_r;
  logic [23:0] dt_r;

  // Sequencer and working registers.
  dsc_pkg::state_t    state_r, state_nxt;
  logic signed [31:0] windup_r;
  logic signed [31:0] rel_r;
  logic [30:0]        cap_r;
  logic               disen_r;
  logic signed [31:0] delta_r;
  logic signed [63:0] kdrel_r;
  logic signed [47:0] tq_r;
  logic signed [31:0] torque_r;
  logic               slip_r;
  logic               neg_r;
  logic               out_valid_r;
  dsc_pkg::out_beat_t out_beat_r;

  // Control outputs of the sequencer.
  logic               accept;
  logic               fin_load;
  logic               div_go;
  logic               mul_sel_dt, mul_sel_kd, mul_sel_ks;

  // Shared units.
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod;
  dsc_pkg::div_req_t  div_req;
  dsc_pkg::div_rsp_t  div_rsp;

  // Datapath intermediates.
  logic signed [31:0] v1, v2;
  logic signed [32:0] rel_diff;
  logic signed [31:0] rel_sat;
  logic signed [63:0] delta_sum;
  logic signed [32:0] ang_sum;
  logic signed [32:0] lim_s;
  logic signed [31:0] ang_sat;
  logic signed [31:0] ang_clamp;
  logic signed [63:0] tsum;
  logic signed [47:0] cap_w;
  logic signed [63:0] num;
  logic [63:0]        num_mag;
  logic signed [32:0] quo_neg;
  logic signed [31:0] aw_angle;

  // --------------------------------------------------------------------------
  // Configuration write port. A write lands at any edge with cfg_we high; the
  // sender must keep its writes to times when the block is idle; not enforced.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r     <= '0;
      kd_r     <= '0;
      lim_r    <= '0;
      lim_en_r <= 1'b1;
      dt_r     <= '0;
      gnd1_r   <= 1'b0;
      gnd2_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dsc_pkg::CFG_STIFFNESS:   ks_r     <= cfg_wdata;
        dsc_pkg::CFG_DAMPING:     kd_r     <= cfg_wdata;
        dsc_pkg::CFG_FLEX_LIMIT:  lim_r    <= cfg_wdata;
        dsc_pkg::CFG_FLEX_ENABLE: lim_en_r <= cfg_wdata[0];
        dsc_pkg::CFG_TIME_STEP:   dt_r     <= cfg_wdata[23:0];
        dsc_pkg::CFG_FIRST_GND:   gnd1_r   <= cfg_wdata[0];
        dsc_pkg::CFG_SECOND_GND:  gnd2_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // The block takes a beat only in S_IDLE. A zero capacity skips straight to
  // the result. The divider runs only when the torque saturated and the
  // stiffness is nonzero.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_beat.clutch_capacity == '0) ? dsc_pkg::S_FIN : dsc_pkg::S_MDT;
        end
      end
      dsc_pkg::S_MDT:   state_nxt = dsc_pkg::S_DELTA;
      dsc_pkg::S_DELTA: state_nxt = dsc_pkg::S_ANGLE;
      dsc_pkg::S_ANGLE: state_nxt = dsc_pkg::S_MKS;
      dsc_pkg::S_MKS:   state_nxt = dsc_pkg::S_TSUM;
      dsc_pkg::S_TSUM:  state_nxt = dsc_pkg::S_TSAT;
      dsc_pkg::S_TSAT:  state_nxt = dsc_pkg::S_NUM;
      dsc_pkg::S_NUM: begin
        state_nxt = (slip_r && (ks_r != '0)) ? dsc_pkg::S_DIV : dsc_pkg::S_FIN;
      end
      dsc_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = dsc_pkg::S_FIN;
        end
      end
      dsc_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = dsc_pkg::S_IDLE;
        end
      end
      default: state_nxt = dsc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: control outputs.
  // The multiplier is issued in S_MDT (rel * dt), S_DELTA (kd * rel) and
  // S_MKS (ks * angle); each product is registered and read in the next state.
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall   = 1'b1;
    fin_load   = 1'b0;
    div_go     = 1'b0;
    mul_sel_dt = 1'b0;
    mul_sel_kd = 1'b0;
    mul_sel_ks = 1'b0;
    unique case (state_r)
      dsc_pkg::S_IDLE:  in_stall   = 1'b0;
      dsc_pkg::S_MDT:   mul_sel_dt = 1'b1;
      dsc_pkg::S_DELTA: mul_sel_kd = 1'b1;
      dsc_pkg::S_MKS:   mul_sel_ks = 1'b1;
      dsc_pkg::S_NUM:   div_go     = slip_r && (ks_r != '0);
      dsc_pkg::S_FIN:   fin_load   = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Shared multiplier with operand selection.
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (mul_sel_dt) begin
      mul_a = {rel_r[31], rel_r};
      mul_b = {9'b0, dt_r};
    end else if (mul_sel_kd) begin
      mul_a = {rel_r[31], rel_r};
      mul_b = {2'b0, kd_r};
    end else if (mul_sel_ks) begin
      mul_a = {windup_r[31], windup_r};
      mul_b = {2'b0, ks_r};
    end
  end

  dsc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // --------------------------------------------------------------------------
  // Datapath arithmetic, one short step per state.
  // --------------------------------------------------------------------------
  // Relative velocity; a grounded body counts as standing still.
  assign v1       = gnd1_r ? 32'sd0 : in_beat.first_velocity;
  assign v2       = gnd2_r ? 32'sd0 : in_beat.second_velocity;
  assign rel_diff = {v1[31], v1} - {v2[31], v2};
  assign rel_sat  = (rel_diff > 33'sh0_7FFF_FFFF) ? dsc_pkg::Q_MAX :
                    (rel_diff < -33'sh0_8000_0000) ? dsc_pkg::Q_MIN : rel_diff[31:0];

  // rel * dt fits 56 signed bits, so the rounded shift by 24 is bits 55..24.
  assign delta_sum = prod + 64'sd8388608;

  // Integrate, saturate, then clamp to the flex limit when it is in force.
  assign ang_sum = {windup_r[31], windup_r} + {delta_r[31], delta_r};
  assign ang_sat = (ang_sum > 33'sh0_7FFF_FFFF) ? dsc_pkg::Q_MAX :
                   (ang_sum < -33'sh0_8000_0000) ? dsc_pkg::Q_MIN : ang_sum[31:0];
  assign lim_s   = {2'b0, lim_r};

  always_comb begin
    ang_clamp = ang_sat;
    if (lim_en_r && (lim_r != '0)) begin
      if ($signed({ang_sat[31], ang_sat}) > lim_s) begin
        ang_clamp = lim_s[31:0];
      end else if ($signed({ang_sat[31], ang_sat}) < -lim_s) begin
        ang_clamp = 32'(-lim_s);
      end
    end
  end

  // ks*angle + kd*rel stays below 2^63 in magnitude; rounding shift by 16.
  assign tsum  = prod + kdrel_r + 64'sd32768;
  assign cap_w = {17'b0, cap_r};

  // Anti-windup numerator: torque in Q32.32 less the damper term.
  assign num     = {{16{torque_r[31]}}, torque_r, 16'b0} - kdrel_r;
  assign num_mag = num[63] ? 64'(-num) : num;

  assign div_req.start   = div_go;
  assign div_req.num_mag = num_mag[62:0];
  assign div_req.den     = ks_r;

  dsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Quotient truncated toward zero, given its sign, then saturated.
  assign quo_neg = -$signed({1'b0, div_rsp.quo});

  always_comb begin
    if (neg_r) begin
      aw_angle = (div_rsp.ovf || (div_rsp.quo > 32'h8000_0000)) ?
                 dsc_pkg::Q_MIN : quo_neg[31:0];
    end else begin
      aw_angle = (div_rsp.ovf || div_rsp.quo[31]) ? dsc_pkg::Q_MAX : div_rsp.quo;
    end
  end

  // --------------------------------------------------------------------------
  // Working registers. The wind-up angle lives in windup_r: it clears on a
  // disengaged beat, takes the clamped angle in S_ANGLE and is replaced by
  // the anti-windup angle when the divider finishes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      windup_r <= '0;
    end else if (accept && (in_beat.clutch_capacity == '0)) begin
      windup_r <= '0;
    end else if (state_r == dsc_pkg::S_ANGLE) begin
      windup_r <= ang_clamp;
    end else if ((state_r == dsc_pkg::S_DIV) && div_rsp.done) begin
      windup_r <= aw_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rel_r    <= rel_sat;
      cap_r    <= in_beat.clutch_capacity;
      disen_r  <= (in_beat.clutch_capacity == '0);
      torque_r <= '0;
      slip_r   <= 1'b0;
    end
    if (state_r == dsc_pkg::S_DELTA) begin
      delta_r <= delta_sum[55:24];
    end
    if (state_r == dsc_pkg::S_ANGLE) begin
      kdrel_r <= prod;
    end
    if (state_r == dsc_pkg::S_TSUM) begin
      tq_r <= tsum[63:16];
    end
    if (state_r == dsc_pkg::S_TSAT) begin
      if (tq_r > cap_w) begin
        torque_r <= {1'b0, cap_r};
        slip_r   <= 1'b1;
      end else if (tq_r < -cap_w) begin
        torque_r <= 32'(-cap_w);
        slip_r   <= 1'b1;
      end else begin
        torque_r <= tq_r[31:0];
        slip_r   <= 1'b0;
      end
    end
    if (div_go) begin
      neg_r <= num[63];
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A finished beat waits here, so a new input beat is
  // taken while the previous result is still stalled downstream.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_beat_r.coupling_torque <= torque_r;
      out_beat_r.apply_first     <= !disen_r && !gnd1_r;
      out_beat_r.apply_second    <= !disen_r && !gnd2_r;
      out_beat_r.slipping        <= slip_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTHESIS
  // The divider reports completion only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == dsc_pkg::S_DIV))
    else $error("divider finished outside the divide state");

  // A disengaged beat clears the wind-up and goes straight to the result.
  a_disengage_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_beat.clutch_capacity == '0)) |=>
      ((windup_r == 32'sd0) && (state_r == dsc_pkg::S_FIN)))
    else $error("disengaged beat did not clear the wind-up angle");

  // A new result appears only from the final state of the sequencer.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == dsc_pkg::S_FIN))
    else $error("result raised outside the final state");
`endif

endmodule

// File: rtl/core/dsc_mul.sv
// ----------------------------------------------------------------------------
// dsc_mul: shared signed multiplier with a registered product
// Every product of the block goes through this one unit, one per cycle.
// ----------------------------------------------------------------------------
module dsc_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [63:0] prod
);

  logic signed [65:0] full;
  logic signed [63:0] prod_r;

  // All operand pairs used here give products that fit in 64 signed bits.
  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= full[63:0];
  end

  assign prod = prod_r;

endmodule

// File: rtl/core/dsc_div.sv
// ----------------------------------------------------------------------------
// dsc_div: iterative restoring divider, one quotient bit per cycle
// Divides a 63-bit magnitude by a nonzero 31-bit divisor into a 32-bit
// quotient and flags a quotient that does not fit in 32 bits.
// ----------------------------------------------------------------------------
module dsc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dsc_pkg::div_req_t req,
  output dsc_pkg::div_rsp_t rsp
);

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic        ovf_r, ovf_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [30:0] den_r, den_nxt;
  logic [31:0] trial;
  logic        ge;

  assign trial = {rem_r, lo_r[31]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    den_nxt  = den_r;
    if (req.start) begin
      // The upper half already holding the divisor means a quotient of 2^32 or more.
      run_nxt = 1'b1;
      ovf_nxt = (req.num_mag[62:32] >= req.den);
      cnt_nxt = '0;
      rem_nxt = req.num_mag[62:32];
      lo_nxt  = req.num_mag[31:0];
      den_nxt = req.den;
    end else if (run_r) begin
      rem_nxt = ge ? 31'(trial - {1'b0, den_r}) : trial[30:0];
      lo_nxt  = {lo_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.quo  = lo_r;

endmodule

// File: tb/driveline_spring_damper_clutch_tb.sv
// ----------------------------------------------------------------------------
// driveline_spring_damper_clutch_tb: self-checking bench for the clutch coupling
// Drives velocity and capacity beats through the valid/stall channel and
// reprograms the coupling registers between phases. A scoreboard class
// tracks the wind-up angle and predicts every torque beat, then compares
// each accepted result field by field.
// ----------------------------------------------------------------------------
module driveline_spring_damper_clutch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsc_pkg::*;

  // Register index that no register decodes; writes to it must be dropped.
  localparam logic [CfgAddrW-1:0] CFG_UNUSED = 3'd7;

  localparam logic [30:0] CAP_MAX  = 31'h7FFF_FFFF;
  localparam logic [30:0] GAIN_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] Q_ONE    = 31'd65536;
  localparam logic [23:0] DT_MAX   = 24'hFF_FFFF;

  // Rounding offsets for the Q16.40 -> Q16.16 and Q32.32 -> Q16.16 steps.
  localparam longint RND24 = 64'sh80_0000;
  localparam longint RND16 = 64'sh8000;

  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 60;
  localparam int MAX_REPORTS     = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: a bit-true copy of the coupling arithmetic plus the queue of
  // torque beats still owed by the block.
  // --------------------------------------------------------------------------
  class torque_scoreboard;
    longint    ks, kd, flex_lim, dt;
    bit        flex_en, first_gnd, second_gnd;
    longint    windup;
    out_beat_t expected_torques[$];
    int        errors;

    function new();
      ks = 0;
      kd = 0;
      flex_lim = 0;
      dt = 0;
      flex_en = 1'b1;
      first_gnd = 1'b0;
      second_gnd = 1'b0;
      windup = 0;
      errors = 0;
    endfunction

    function longint sat_q(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
      case (addr)
        CFG_STIFFNESS:   ks = longint'({1'b0, data});
        CFG_DAMPING:     kd = longint'({1'b0, data});
        CFG_FLEX_LIMIT:  flex_lim = longint'({1'b0, data});
        CFG_FLEX_ENABLE: flex_en = data[0];
        CFG_TIME_STEP:   dt = longint'({8'b0, data[23:0]});
        CFG_FIRST_GND:   first_gnd = data[0];
        CFG_SECOND_GND:  second_gnd = data[0];
        default: ;
      endcase
    endfunction

    function void note_step(in_beat_t b);
      longint    cap, v1, v2, rel, ang, tq, num;
      bit        slip;
      out_beat_t e;
      e = '0;
      slip = 1'b0;
      cap = longint'({1'b0, b.clutch_capacity});
      if (cap == 0) begin
        windup = 0;
      end else begin
        v1 = first_gnd ? 64'sd0 : longint'($signed(b.first_velocity));
        v2 = second_gnd ? 64'sd0 : longint'($signed(b.second_velocity));
        rel = sat_q(v1 - v2);
        ang = sat_q(windup + ((rel * dt + RND24) >>> 24));
        if (flex_en && flex_lim > 0) begin
          if (ang > flex_lim) ang = flex_lim;
          else if (ang < -flex_lim) ang = -flex_lim;
        end
        tq = (ks * ang + kd * rel + RND16) >>> 16;
        if (tq > cap || tq < -cap) begin
          tq = (tq > cap) ? cap : -cap;
          slip = 1'b1;
          if (ks > 0) begin
            num = tq * 64'sd65536 - kd * rel;
            ang = sat_q(num / ks);
          end
        end
        windup = ang;
        e.coupling_torque = tq[31:0];
        e.apply_first = !first_gnd;
        e.apply_second = !second_gnd;
        e.slipping = slip;
      end
      expected_torques.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
      if (errors < MAX_REPORTS)
        $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got_v, exp_v);
      errors++;
    endtask

    task check_torque(out_beat_t got);
      out_beat_t e;
      if (expected_torques.size() == 0) begin
        report_mismatch("result beat with nothing expected", got.coupling_torque, '0);
        return;
      end
      e = expected_torques.pop_front();
      if (got.coupling_torque !== e.coupling_torque)
        report_mismatch("coupling_torque", got.coupling_torque, e.coupling_torque);
      if (got.apply_first !== e.apply_first)
        report_mismatch("apply_first", 32'(got.apply_first), 32'(e.apply_first));
      if (got.apply_second !== e.apply_second)
        report_mismatch("apply_second", 32'(got.apply_second), 32'(e.apply_second));
      if (got.slipping !== e.slipping)
        report_mismatch("slipping", 32'(got.slipping), 32'(e.slipping));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_beat_t            in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_beat;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  torque_scoreboard sb = new();

  // Idle percentages for each side; the main sequence changes them per phase.
  int tx_idle_pct = 9;
  int rx_idle_pct = 83;

  // Beats handed to the block and result beats taken from it. The main
  // sequence compares these to know when the block has gone quiet.
  int beats_sent = 0;
  int results_seen = 0;

  driveline_spring_damper_clutch i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random on every cycle, so that back-pressure can
  // land on any cycle of the block's work, including the divider's.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Both channels are sampled at the clock edge, before any nonblocking
  // update of that edge lands, so the sampled values are the ones the block
  // acted on.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_step(in_beat);
      if (out_valid && !out_stall) begin
        sb.check_torque(out_beat);
        results_seen++;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("driveline_spring_damper_clutch_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic in_beat_t beat_of(logic signed [31:0] v1, logic signed [31:0] v2,
                                       logic [30:0] cap);
    in_beat_t b;
    b.first_velocity = v1;
    b.second_velocity = v2;
    b.clutch_capacity = cap;
    return b;
  endfunction

  // Velocities are mostly within a plausible shaft speed range, with some
  // large values and the corners of the signed range mixed in.
  function automatic logic signed [31:0] pick_velocity();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $signed($urandom_range(0, 32'h80_0000)) - 32'sh40_0000;
      4, 5:       return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      6:          return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [30:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CAP_MAX;
      2, 3, 4: return 31'($urandom_range(1, 32'h1_0000));
      5, 6:    return 31'($urandom_range(32'h1_0000, 32'h100_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return GAIN_MAX;
      2, 3, 4, 5: return 31'($urandom_range(32'h1000, 32'h4_0000));
      6, 7:       return 31'($urandom_range(32'h4_0000, 32'h100_0000));
      default:    return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] pick_flex();
    case ($urandom_range(0, 7))
      0:          return '0;
      1:          return GAIN_MAX;
      2, 3, 4, 5: return 31'($urandom_range(32'h4000, 32'h10_0000));
      default:    return 31'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_dt();
    case ($urandom_range(0, 9))
      0:                return '0;
      1:                return DT_MAX;
      2, 3, 4, 5, 6:    return 24'($urandom_range(32'h1000, 32'h1_0000));
      default:          return 24'($urandom);
    endcase
  endfunction

  // Offers one beat: the sender may idle first, then holds valid and the
  // payload steady until the block takes the beat.
  task automatic push_beat(input in_beat_t b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_beat <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Stops offering beats and waits for every outstanding result. Each beat
  // yields exactly one result, so the block is idle once the counts match.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_seen < beats_sent) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    sb.write_reg(addr, data);
    @(posedge clk);
  endtask

  // Rewrites every register while the block is idle. The narrow registers
  // get random upper bits, which the block has to ignore, and now and then
  // a write to the undecoded index goes along.
  task automatic configure(input logic [30:0] ks, input logic [30:0] kd,
                           input logic [30:0] flex, input bit flex_on,
                           input logic [23:0] dt, input bit gnd1, input bit gnd2);
    logic [31:0] junk;
    junk = $urandom;
    drain_results();
    put_reg(CFG_STIFFNESS, ks);
    put_reg(CFG_DAMPING, kd);
    put_reg(CFG_FLEX_LIMIT, flex);
    put_reg(CFG_FLEX_ENABLE, {junk[29:0], flex_on});
    put_reg(CFG_TIME_STEP, {junk[31:25], dt});
    put_reg(CFG_FIRST_GND, {junk[30:1], gnd1});
    put_reg(CFG_SECOND_GND, {junk[31:2], gnd2});
    if ($urandom_range(0, 2) == 0) put_reg(CFG_UNUSED, 31'($urandom));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int                 base, offset, noise;
    logic [30:0]        phase_cap, cap;
    logic signed [31:0] v1, v2;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. First the reset settings: both gains are zero, so the
    // torque must come out as zero whatever the velocities are.
    push_beat(beat_of(Q_MAX, Q_MIN, CAP_MAX));
    push_beat(beat_of(-32'sd1, 32'sd1, 31'd1));

    // A well-behaved coupling with a flex limit: saturating relative
    // velocity, a disengaged clutch, a tiny capacity that forces slip and
    // anti-windup, and a step with no slip.
    configure(Q_ONE, 31'd32768, 31'd131072, 1'b1, 24'd16384, 1'b0, 1'b0);
    push_beat(beat_of(Q_MAX, Q_MIN, CAP_MAX));
    push_beat(beat_of(Q_MIN, Q_MAX, CAP_MAX));
    push_beat(beat_of(32'sh10_0000, 32'sd0, 31'd1));
    push_beat(beat_of(32'sh10_0000, 32'sd0, 31'h1_0000));
    push_beat(beat_of(32'sd0, 32'sd0, 31'd0));
    push_beat(beat_of(32'sd1, -32'sd1, CAP_MAX));
    push_beat(beat_of(32'sd0, 32'sh10_0000, 31'h7_0000));

    // Every gain, the limit and the time step at their top values with the clamp off: the angle and the
    // intermediate sums run into saturation, and the divider sees its
    // largest operands.
    configure(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0, DT_MAX, 1'b0, 1'b0);
    push_beat(beat_of(Q_MAX, Q_MIN, CAP_MAX));
    push_beat(beat_of(Q_MAX, Q_MIN, CAP_MAX));
    push_beat(beat_of(Q_MIN, Q_MAX, 31'd1));
    push_beat(beat_of(Q_MAX, Q_MAX, CAP_MAX));
    push_beat(beat_of(-32'sd1, 32'sd0, 31'd1));

    // Both bodies grounded with zero stiffness: relative velocity is zero,
    // both apply flags drop, and slip leaves the angle as integrated.
    configure(31'd0, Q_ONE, 31'd0, 1'b1, 24'd0, 1'b1, 1'b1);
    push_beat(beat_of(Q_MAX, Q_MIN, 31'd1));
    push_beat(beat_of(32'sd123, -32'sd5, CAP_MAX));
    push_beat(beat_of(32'sd0, 32'sd0, 31'd0));

    // One side grounded at a time; a zero flex limit leaves the clamp off
    // even though it is enabled.
    configure(31'd131072, 31'd0, 31'd0, 1'b1, DT_MAX, 1'b1, 1'b0);
    push_beat(beat_of(Q_MAX, 32'sh20_0000, 31'h10_0000));
    push_beat(beat_of(32'sd0, -32'sh20_0000, 31'h10_0000));
    configure(31'd131072, 31'd4096, 31'd65536, 1'b1, 24'd65536, 1'b0, 1'b1);
    push_beat(beat_of(32'sh20_0000, Q_MIN, 31'h10_0000));
    push_beat(beat_of(-32'sh20_0000, 32'sd0, 31'h10_0000));

    // Random part. Most beats follow a drifting pair of shaft speeds with a
    // steady offset and a steady capacity, so the wind-up angle builds up
    // over many steps, reaches the flex limit and slips; the rest are loose
    // beats from anywhere in the field ranges.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 9;
        rx_idle_pct = 83;
      end else if (p < 7) begin
        tx_idle_pct = 83;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if (p == 0)
        configure(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1, DT_MAX, 1'b0, 1'b0);
      else
        configure(pick_gain(), pick_gain(), pick_flex(), ($urandom_range(0, 3) != 0),
                  pick_dt(), ($urandom_range(0, 9) == 0), ($urandom_range(0, 9) == 0));

      base = $signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
      offset = pick_velocity();
      phase_cap = pick_capacity();
      if (phase_cap == '0) phase_cap = 31'h8_0000;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Once in the run the sender holds off until the block has handed
        // back everything it owes, then resumes mid-phase.
        if (p == 5 && n == 20) drain_results();

        if ($urandom_range(0, 9) < 7) begin
          noise = int'($urandom_range(0, 4096)) - 2048;
          base = base + noise;
          v1 = base + offset + (int'($urandom_range(0, 512)) - 256);
          v2 = base + (int'($urandom_range(0, 512)) - 256);
          case ($urandom_range(0, 19))
            0:       cap = '0;
            1, 2:    cap = pick_capacity();
            default: cap = phase_cap;
          endcase
        end else begin
          v1 = pick_velocity();
          v2 = pick_velocity();
          cap = pick_capacity();
        end
        push_beat(beat_of(v1, v2, cap));
      end
    end

    // Wind down: wait for every owed result, then give the block time to
    // show any stray beat before the verdict.
    drain_results();
    repeat (HOLD_CYCLES) @(posedge clk);
    if (sb.expected_torques.size() != 0)
      sb.report_mismatch("result beats never delivered", sb.expected_torques.size(), '0);

    if (sb.errors == 0)
      $display("driveline_spring_damper_clutch_tb: done, clean");
    else
      $display("driveline_spring_damper_clutch_tb: done, errors");
    $finish;
  end

endmodule

// File: driveline_spring_damper_clutch.f
rtl/core/dsc_pkg.sv
rtl/core/dsc_mul.sv
rtl/core/dsc_div.sv
rtl/core/driveline_spring_damper_clutch.sv
tb/driveline_spring_damper_clutch_tb.sv
